@@ design/bfea_pkg.sv @@
// Shared types, codes and constants for the best-fit extent allocator.
package bfea_pkg;

  // Default table depth (number of extent slots)
  localparam int DEF_MAX_EXTENTS = 1024;

  // Pages under management and the first page handed out after reset
  localparam int TOTAL_PAGES = 65536;
  localparam logic [15:0] FIRST_FREE_PAGE = 16'd2;
  localparam logic [15:0] INIT_LENGTH = 16'((TOTAL_PAGES - 2) % 65536);

  // Request codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_APPEND,
    S_DONE
  } fsm_state_t;

  // Control from the sequencer to the best-fit compare unit
  typedef struct packed {
    logic clear;
    logic eval;
  } scan_ctrl_t;

  // Pack an extent: first page low, length high
  function automatic logic [31:0] pack_extent(input logic [15:0] first,
                                              input logic [15:0] len);
    return {len, first};
  endfunction

endpackage

@@ design/best_fit_extent_allocator.sv @@
// Top level: sequencer, extent table and result register of the allocator.
//
//   channel | direction | fields                                  | handshake
//   --------+-----------+-----------------------------------------+-----------------
//   request | in        | operation, page_count, start_page       | in_valid/in_ready
//   result  | out       | granted_start, granted_length, status   | out_valid/out_ready
//
// A free is taken in S_IDLE and posted from S_DONE. An allocate walks the table through the
// single RAM read port, one entry a cycle: a best-fit search over N entries in S_SCAN,
// then S_SHIFT closes the gap at the chosen slot B, and S_APPEND appends any remainder
// before the result is posted.
// After reset, S_INIT seeds slot 0, and no request is taken while it does.
// One request is in work at a time; a result waiting in the output register
// does not stop the next request from being taken.
module best_fit_extent_allocator
  import bfea_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [15:0] page_count,
  input  logic [15:0] start_page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] granted_start,
  output logic [15:0] granted_length,
  output logic [1:0]  status
);

  localparam int ADDR_W = $clog2(MAX_EXTENTS);
  localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);

  fsm_state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pipe_idx;
  logic             pipe_valid;
  logic [15:0]      req;
  logic [15:0]      res_start;
  logic [15:0]      res_len;
  status_t          res_status;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;

  scan_ctrl_t       scan_ctrl;
  logic             found;
  logic [CNT_W-1:0] best_idx;
  logic [15:0]      best_start;
  logic [15:0]      best_len;
  logic             split;
  logic [15:0]      rem_start;
  logic [15:0]      rem_len;

  logic accept;
  logic issue;
  logic walk_done;
  logic out_free;
  logic free_ok;

  assign accept    = in_valid && in_ready;
  assign issue     = idx < count;
  assign walk_done = !issue && !pipe_valid;
  assign out_free  = !out_valid || out_ready;
  assign free_ok   = (page_count != 16'd0) && (count < CNT_MAX);

  bfea_ram #(
    .WIDTH (32),
    .DEPTH (MAX_EXTENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfea_scan #(
    .IDX_W (CNT_W)
  ) u_scan (
    .clk        (clk),
    .ctrl       (scan_ctrl),
    .req        (req),
    .entry_idx  (pipe_idx),
    .entry      (rd_data),
    .found      (found),
    .best_idx   (best_idx),
    .best_start (best_start),
    .best_len   (best_len),
    .split      (split),
    .rem_start  (rem_start),
    .rem_len    (rem_len)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:   state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_next = (op_t'(operation) == OP_FREE) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (walk_done) begin
          state_next = found ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        if (walk_done) begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_INIT;
    endcase
  end

  // Table port and compare-unit controls
  always_comb begin
    in_ready        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = count[ADDR_W-1:0];
    wr_data         = pack_extent(start_page, page_count);
    rd_addr         = idx[ADDR_W-1:0];
    scan_ctrl.clear = 1'b0;
    scan_ctrl.eval  = 1'b0;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = pack_extent(FIRST_FREE_PAGE, INIT_LENGTH);
      end
      S_IDLE: begin
        in_ready        = 1'b1;
        scan_ctrl.clear = 1'b1;
        wr_en           = accept && (op_t'(operation) == OP_FREE) && free_ok;
      end
      S_SCAN: begin
        scan_ctrl.eval = pipe_valid;
      end
      S_SHIFT: begin
        wr_en   = pipe_valid;
        wr_addr = ADDR_W'(pipe_idx - 1'b1);
        wr_data = rd_data;
      end
      S_APPEND: begin
        wr_en   = split;
        wr_data = pack_extent(rem_start, rem_len);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      count      <= CNT_W'(1);
      pipe_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          pipe_valid <= 1'b0;
          if (wr_en) begin
            count <= count + 1'b1;
          end
        end
        S_SCAN, S_SHIFT: begin
          pipe_valid <= issue;
          if (state == S_SHIFT && walk_done) begin
            count <= count - 1'b1;
          end
        end
        S_APPEND: begin
          pipe_valid <= 1'b0;
          if (split) begin
            count <= count + 1'b1;
          end
        end
        default: pipe_valid <= 1'b0;
      endcase
      // Output register: load when the result is posted, drop when taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk index, request and result registers
  always_ff @(posedge clk) begin
    pipe_idx <= idx;
    case (state)
      S_IDLE: begin
        idx        <= '0;
        req        <= page_count;
        res_start  <= 16'd0;
        res_len    <= 16'd0;
        res_status <= ST_OK;
        if (op_t'(operation) == OP_FREE) begin
          if (page_count == 16'd0) begin
            res_status <= ST_ZERO;
          end else if (count >= CNT_MAX) begin
            res_status <= ST_FULL;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx <= idx + 1'b1;
        end else if (walk_done) begin
          idx <= CNT_W'(best_idx + 1'b1);
          if (!found) begin
            res_status <= ST_NO_FIT;
          end
        end
      end
      S_SHIFT: begin
        if (issue) begin
          idx <= idx + 1'b1;
        end
      end
      S_APPEND: begin
        res_start <= best_start;
        res_len   <= split ? req : best_len;
      end
      default: ;
    endcase
    // Post the result
    if (state == S_DONE && out_free) begin
      granted_start  <= res_start;
      granted_length <= res_len;
      status         <= res_status;
    end
  end

endmodule

@@ design/bfea_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bfea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/bfea_scan.sv @@
// Best-fit compare unit: tracks the shortest fitting extent over a table walk.
module bfea_scan
  import bfea_pkg::*;
#(
  parameter int IDX_W = 11
) (
  input  logic             clk,
  input  scan_ctrl_t       ctrl,
  input  logic [15:0]      req,
  input  logic [IDX_W-1:0] entry_idx,
  input  logic [31:0]      entry,
  output logic             found,
  output logic [IDX_W-1:0] best_idx,
  output logic [15:0]      best_start,
  output logic [15:0]      best_len,
  output logic             split,
  output logic [15:0]      rem_start,
  output logic [15:0]      rem_len
);

  logic [15:0] entry_len;
  logic        take;

  assign entry_len = entry[31:16];

  // Fits, and strictly shorter than the best so far (oldest wins ties)
  assign take = (entry_len >= req) && (!found || (entry_len < best_len));

  // Hold the best candidate
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.eval && take) begin
      found      <= 1'b1;
      best_idx   <= entry_idx;
      best_start <= entry[15:0];
      best_len   <= entry_len;
    end
  end

  // Remainder of the chosen extent
  assign split     = best_len > req;
  assign rem_start = best_start + req;
  assign rem_len   = best_len - req;

endmodule
